/* sv/status_led_pattern_controller_defines.svh */
// ----------------------------------------------------------------------------
// Status LED pattern controller: assertion macros
// Simulation-only property checks; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH
`define STATUS_LED_PATTERN_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define SLPC_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a trigger is followed in the next clock cycle by a consequence.
`define SLPC_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define SLPC_ASSERT(label, clk, rst_n, expr, msg)
`define SLPC_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)

`endif

`endif

/* sv/slpc_pkg.sv */
// ----------------------------------------------------------------------------
// Status LED pattern controller package
// Widths, operation and mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package slpc_pkg;

    // Width of the millisecond timers and the blink interval counter
    localparam int TIME_BITS = 16;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 8;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam t_time TIME_MAX = '1;

    // Request operations
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_FLASH = 2'd1,
        OP_DIP   = 2'd2
    } t_op;

    // LED modes
    typedef enum logic [1:0] {
        MODE_SOLID = 2'd0,
        MODE_SLOW  = 2'd1,
        MODE_FAST  = 2'd2,
        MODE_HOLD  = 2'd3
    } t_mode;

    // Register indexes
    localparam t_idx CFG_LED_MODE       = 3'd0;
    localparam t_idx CFG_SLOW_PERIOD    = 3'd1;
    localparam t_idx CFG_FAST_PERIOD    = 3'd2;
    localparam t_idx CFG_FLASH_ON_TIME  = 3'd3;
    localparam t_idx CFG_FLASH_OFF_TIME = 3'd4;
    localparam t_idx CFG_DIP_TIME       = 3'd5;

    // Register reset values
    localparam t_cfg RST_SLOW_PERIOD = 16'd500;
    localparam t_cfg RST_FAST_PERIOD = 16'd100;
    localparam t_cfg RST_FLASH_TIME  = 16'd20;
    localparam t_cfg RST_DIP_TIME    = 16'd100;

    // Saturate a configured time to the timer range
    function automatic t_time clamp_time(input t_cfg t);
        if (32'(t) > 32'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return t_time'(t);
    endfunction

endpackage

/* sv/slpc_req_if.sv */
// ----------------------------------------------------------------------------
// Status LED pattern controller: request channel
// Valid/ready channel carrying one event (tick, flash or dip).
// ----------------------------------------------------------------------------
interface slpc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] pulse_count;

    modport source (output valid, output op, output pulse_count, input ready);
    modport sink   (input valid, input op, input pulse_count, output ready);
endinterface

/* sv/slpc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Status LED pattern controller: result channel
// Valid/ready channel carrying the LED level and busy flags.
// ----------------------------------------------------------------------------
interface slpc_rsp_if;
    logic valid;
    logic ready;
    logic led_level;
    logic flash_busy;
    logic dip_busy;

    modport source (output valid, output led_level, output flash_busy,
                    output dip_busy, input ready);
    modport sink   (input valid, input led_level, input flash_busy,
                    input dip_busy, output ready);
endinterface

/* sv/status_led_pattern_controller.sv */
// ----------------------------------------------------------------------------
// Status LED pattern controller
// Drives one status LED from millisecond ticks, flash requests and dips.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : valid/ready request channel, op (tick, flash, dip) and
//            pulse_count (flash pulses, 0 means 256).
//   o_rsp  : valid/ready result channel, one result per request: LED level,
//            flash_busy and dip_busy after that request.
//   i_cfg_*: write port for the six registers (mode, periods, flash times,
//            dip time); write only while no request is in flight.
// A request accepted at a clock edge is shown on o_rsp right after that
// edge. Throughput is one request per cycle while results are taken; the
// state update is a single pass of logic between the request handshake and
// the result register. The request side stays ready while the result
// register is empty or being taken, so a stalled receiver holds the result
// and back-pressures i_req for exactly as long as it stalls.
// Reset clears all state (LED off, no flash, no dip), sets mode to slow
// blink and loads the register defaults; the result register empties.
// ----------------------------------------------------------------------------
`include "status_led_pattern_controller_defines.svh"

module status_led_pattern_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slpc_req_if.sink              i_req,
    slpc_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  slpc_pkg::t_idx        i_cfg_idx,
    input  slpc_pkg::t_cfg        i_cfg_data
);
    import slpc_pkg::*;

    // Configuration registers
    t_mode r_mode;
    t_cfg  r_slow_period;
    t_cfg  r_fast_period;
    t_cfg  r_flash_on;
    t_cfg  r_flash_off;
    t_cfg  r_dip_time;

    // Controller state
    logic  r_pin_level, n_pin_level;
    logic  r_blink_phase, n_blink_phase;
    logic  r_flashing, n_flashing;
    logic  r_flash_off_phase, n_flash_off_phase;
    t_cnt  r_pulses_left, n_pulses_left;
    t_time r_flash_timer, n_flash_timer;
    logic  r_dipping, n_dipping;
    t_time r_dip_timer, n_dip_timer;
    t_time r_blink_elapsed, n_blink_elapsed;

    // Result register
    logic  r_out_valid;
    logic  r_out_led;
    logic  r_out_flash;
    logic  r_out_dip;

    logic  w_in_ready;
    logic  w_accept;
    t_time w_period;

    // Take a request while the result register is free or being drained
    assign w_in_ready  = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && w_in_ready;
    assign i_req.ready = w_in_ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.led_level  = r_out_led;
    assign o_rsp.flash_busy = r_out_flash;
    assign o_rsp.dip_busy   = r_out_dip;

    // Blink interval for the current mode
    assign w_period = (r_mode == MODE_FAST) ? clamp_time(r_fast_period)
                                            : clamp_time(r_slow_period);

    // Compute the state after one request, then apply a mode write
    always_comb begin
        n_pin_level       = r_pin_level;
        n_blink_phase     = r_blink_phase;
        n_flashing        = r_flashing;
        n_flash_off_phase = r_flash_off_phase;
        n_pulses_left     = r_pulses_left;
        n_flash_timer     = r_flash_timer;
        n_dipping         = r_dipping;
        n_dip_timer       = r_dip_timer;
        n_blink_elapsed   = r_blink_elapsed;

        if (w_accept) begin
            unique case (t_op'(i_req.op))
                OP_TICK: begin
                    // Advance timers, saturating at both ends
                    if (r_flash_timer != '0) begin
                        n_flash_timer = r_flash_timer - t_time'(1);
                    end
                    if (r_dip_timer != '0) begin
                        n_dip_timer = r_dip_timer - t_time'(1);
                    end
                    if (r_blink_elapsed != TIME_MAX) begin
                        n_blink_elapsed = r_blink_elapsed + t_time'(1);
                    end

                    if (r_flashing) begin
                        // Flash sequence owns the pin
                        if (n_flash_timer == '0) begin
                            if (!r_flash_off_phase) begin
                                n_pin_level       = 1'b0;
                                n_blink_phase     = 1'b0;
                                n_flash_off_phase = 1'b1;
                                n_flash_timer     = clamp_time(r_flash_off);
                            end else begin
                                n_pulses_left = r_pulses_left - t_cnt'(1);
                                if (n_pulses_left == '0) begin
                                    n_flashing      = 1'b0;
                                    n_blink_elapsed = '0;
                                end else begin
                                    n_pin_level       = 1'b1;
                                    n_blink_phase     = 1'b1;
                                    n_flash_off_phase = 1'b0;
                                    n_flash_timer     = clamp_time(r_flash_on);
                                end
                            end
                        end
                    end else if (r_dipping) begin
                        // Drop the dip once its time runs out
                        if (n_dip_timer == '0) begin
                            n_dipping       = 1'b0;
                            n_blink_elapsed = '0;
                        end
                    end else begin
                        unique case (r_mode)
                            MODE_SOLID: begin
                                n_pin_level = 1'b1;
                            end
                            MODE_SLOW, MODE_FAST: begin
                                if (n_blink_elapsed >= w_period) begin
                                    n_blink_phase   = !r_blink_phase;
                                    n_pin_level     = !r_blink_phase;
                                    n_blink_elapsed = '0;
                                end
                            end
                            MODE_HOLD: begin
                            end
                        endcase
                    end
                end
                OP_FLASH: begin
                    // Restart the flash sequence
                    n_pulses_left     = t_cnt'(i_req.pulse_count);
                    n_flash_off_phase = 1'b0;
                    n_flashing        = 1'b1;
                    n_flash_timer     = clamp_time(r_flash_on);
                    n_pin_level       = 1'b1;
                    n_blink_phase     = 1'b1;
                end
                OP_DIP: begin
                    // Start or restart a dip unless a flash is running
                    if (!r_flashing) begin
                        n_dipping   = 1'b1;
                        n_dip_timer = clamp_time(r_dip_time);
                        n_pin_level = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        // Mode write cancels a flash and restarts the blink interval
        if (i_cfg_we && (i_cfg_idx == CFG_LED_MODE)) begin
            n_flashing      = 1'b0;
            n_blink_elapsed = '0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SLOW;
            r_slow_period <= RST_SLOW_PERIOD;
            r_fast_period <= RST_FAST_PERIOD;
            r_flash_on    <= RST_FLASH_TIME;
            r_flash_off   <= RST_FLASH_TIME;
            r_dip_time    <= RST_DIP_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LED_MODE:       r_mode        <= t_mode'(i_cfg_data[1:0]);
                CFG_SLOW_PERIOD:    r_slow_period <= i_cfg_data;
                CFG_FAST_PERIOD:    r_fast_period <= i_cfg_data;
                CFG_FLASH_ON_TIME:  r_flash_on    <= i_cfg_data;
                CFG_FLASH_OFF_TIME: r_flash_off   <= i_cfg_data;
                CFG_DIP_TIME:       r_dip_time    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_level       <= 1'b0;
            r_blink_phase     <= 1'b0;
            r_flashing        <= 1'b0;
            r_flash_off_phase <= 1'b0;
            r_pulses_left     <= '0;
            r_flash_timer     <= '0;
            r_dipping         <= 1'b0;
            r_dip_timer       <= '0;
            r_blink_elapsed   <= '0;
        end else begin
            r_pin_level       <= n_pin_level;
            r_blink_phase     <= n_blink_phase;
            r_flashing        <= n_flashing;
            r_flash_off_phase <= n_flash_off_phase;
            r_pulses_left     <= n_pulses_left;
            r_flash_timer     <= n_flash_timer;
            r_dipping         <= n_dipping;
            r_dip_timer       <= n_dip_timer;
            r_blink_elapsed   <= n_blink_elapsed;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_led   <= n_pin_level;
            r_out_flash <= n_flashing;
            r_out_dip   <= n_dipping;
        end
    end

    // Checks
    `SLPC_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_out_valid,
        "accepted request left no result")
    `SLPC_ASSERT_NEXT(a_dip_forces_off, i_clk, i_rst_n,
        w_accept && (i_req.op == OP_DIP) && !r_flashing,
        r_dipping && !r_pin_level && r_out_dip && !r_out_led,
        "dip did not force the LED off")
    `SLPC_ASSERT_NEXT(a_flash_starts_on, i_clk, i_rst_n,
        w_accept && (i_req.op == OP_FLASH) && !i_cfg_we,
        r_flashing && r_pin_level && !r_flash_off_phase && r_out_flash,
        "flash did not start with the LED on")
    `SLPC_ASSERT(a_stall_blocks_req, i_clk, i_rst_n,
        !(r_out_valid && !o_rsp.ready && w_accept),
        "request accepted over a stalled result")

endmodule

/* tb/status_led_pattern_controller_tb.sv */
// ----------------------------------------------------------------------------
// Status LED pattern controller testbench
// Drives tick, flash, dip and spare requests through the valid/ready request
// channel and checks every result against a cycle-free behavioral model of
// the LED logic. Directed tests cover each mode, the zero and full-scale
// times, flash and dip interactions and the 256-pulse flash. A long random
// run follows across many register settings under varying back-pressure.
// ----------------------------------------------------------------------------
module status_led_pattern_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slpc_pkg::*;

    // Spare codes that the block must ignore
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam t_idx       CFG_SPARE_A = 3'd6;
    localparam t_idx       CFG_SPARE_B = 3'd7;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned RAND_PHASES = 12;
    localparam int unsigned PHASE_ITEMS = 74;

    typedef struct packed {
        logic led;
        logic flash;
        logic dip;
    } t_led_status;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_idx   i_cfg_idx;
    t_cfg   i_cfg_data;

    slpc_req_if req_if ();
    slpc_rsp_if rsp_if ();

    status_led_pattern_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Expected LED status, oldest first
    t_led_status status_q[$];
    int unsigned mismatches = 0;
    int unsigned src_idle_pct = 20;
    int unsigned sink_idle_pct = 46;

    // Model registers
    t_mode reg_mode;
    t_cfg  reg_slow;
    t_cfg  reg_fast;
    t_cfg  reg_on;
    t_cfg  reg_off;
    t_cfg  reg_dip;

    // Model state
    logic  st_pin;
    logic  st_blink;
    logic  st_flashing;
    logic  st_flash_off;
    t_cnt  st_pulses;
    t_time st_flash_tmr;
    logic  st_dipping;
    t_time st_dip_tmr;
    t_time st_elapsed;

    // ------------------------------------------------------------------------
    // LED model
    // ------------------------------------------------------------------------
    function automatic void reset_led_model();
        reg_mode     = MODE_SLOW;
        reg_slow     = RST_SLOW_PERIOD;
        reg_fast     = RST_FAST_PERIOD;
        reg_on       = RST_FLASH_TIME;
        reg_off      = RST_FLASH_TIME;
        reg_dip      = RST_DIP_TIME;
        st_pin       = 1'b0;
        st_blink     = 1'b0;
        st_flashing  = 1'b0;
        st_flash_off = 1'b0;
        st_pulses    = '0;
        st_flash_tmr = '0;
        st_dipping   = 1'b0;
        st_dip_tmr   = '0;
        st_elapsed   = '0;
    endfunction

    // Saturate a register value to the timer range
    function automatic t_time to_ticks(input t_cfg v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'(TIME_MAX)) ? TIME_MAX : t_time'(wide);
    endfunction

    function automatic void apply_reg_write(input t_idx idx, input t_cfg data);
        case (idx)
            CFG_LED_MODE: begin
                // A mode write drops any flash and restarts the interval
                reg_mode    = t_mode'(data[1:0]);
                st_flashing = 1'b0;
                st_elapsed  = '0;
            end
            CFG_SLOW_PERIOD:    reg_slow = data;
            CFG_FAST_PERIOD:    reg_fast = data;
            CFG_FLASH_ON_TIME:  reg_on   = data;
            CFG_FLASH_OFF_TIME: reg_off  = data;
            CFG_DIP_TIME:       reg_dip  = data;
            default: ;
        endcase
    endfunction

    function automatic void advance_ms_tick();
        t_cfg period;
        if (st_flash_tmr != '0) st_flash_tmr--;
        if (st_dip_tmr != '0) st_dip_tmr--;
        if (st_elapsed != TIME_MAX) st_elapsed++;

        // Flash owns the pin while it runs
        if (st_flashing) begin
            if (st_flash_tmr == '0) begin
                if (!st_flash_off) begin
                    st_pin       = 1'b0;
                    st_blink     = 1'b0;
                    st_flash_off = 1'b1;
                    st_flash_tmr = to_ticks(reg_off);
                end else begin
                    st_pulses = st_pulses - t_cnt'(1);
                    if (st_pulses == '0) begin
                        st_flashing = 1'b0;
                        st_elapsed  = '0;
                    end else begin
                        st_pin       = 1'b1;
                        st_blink     = 1'b1;
                        st_flash_off = 1'b0;
                        st_flash_tmr = to_ticks(reg_on);
                    end
                end
            end
        end else if (st_dipping) begin
            if (st_dip_tmr == '0) begin
                st_dipping = 1'b0;
                st_elapsed = '0;
            end
        end else begin
            case (reg_mode)
                MODE_SOLID: st_pin = 1'b1;
                MODE_SLOW, MODE_FAST: begin
                    period = (reg_mode == MODE_SLOW) ? reg_slow : reg_fast;
                    if (st_elapsed >= to_ticks(period)) begin
                        st_blink   = ~st_blink;
                        st_pin     = st_blink;
                        st_elapsed = '0;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic t_led_status predict_led_status(input logic [1:0] op,
                                                       input t_cnt cnt);
        t_led_status s;
        case (op)
            OP_TICK: advance_ms_tick();
            OP_FLASH: begin
                st_pulses    = cnt;
                st_flash_off = 1'b0;
                st_flashing  = 1'b1;
                st_flash_tmr = to_ticks(reg_on);
                st_pin       = 1'b1;
                st_blink     = 1'b1;
            end
            OP_DIP: begin
                if (!st_flashing) begin
                    st_dipping = 1'b1;
                    st_dip_tmr = to_ticks(reg_dip);
                    st_pin     = 1'b0;
                end
            end
            default: ;
        endcase
        s.led   = st_pin;
        s.flash = st_flashing;
        s.dip   = st_dipping;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on each request, check each result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_led_status want;
        t_led_status got;
        if (!i_rst_n) begin
            reset_led_model();
        end else begin
            if (i_cfg_we) begin
                apply_reg_write(i_cfg_idx, i_cfg_data);
            end
            if (req_if.valid && req_if.ready) begin
                status_q.push_back(predict_led_status(req_if.op, req_if.pulse_count));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{rsp_if.led_level, rsp_if.flash_busy, rsp_if.dip_busy};
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result %b with no request pending", got));
                end else begin
                    want = status_q.pop_front();
                    if (got.led !== want.led)
                        report_mismatch($sformatf("led_level expected %b got %b",
                                                  want.led, got.led));
                    if (got.flash !== want.flash)
                        report_mismatch($sformatf("flash_busy expected %b got %b",
                                                  want.flash, got.flash));
                    if (got.dip !== want.dip)
                        report_mismatch($sformatf("dip_busy expected %b got %b",
                                                  want.dip, got.dip));
                end
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // End the run when no handshake happens for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (req_if.valid && req_if.ready) ||
                (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status_led_pattern_controller verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Send one request, with a random gap ahead of it
    task automatic send_request(input logic [1:0] op, input t_cnt cnt);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= op;
        req_if.pulse_count <= cnt;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_request(OP_TICK, t_cnt'($urandom_range(255)));
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_idx idx, input t_cfg data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset state: slow blink, LED off, spare op changes nothing
    task automatic test_reset_state();
        send_request(OP_TICK, 8'h00);
        send_request(OP_SPARE, 8'hFF);
        send_request(OP_TICK, 8'hA5);
        wait_idle();
    endtask

    // Solid and hold modes, dip end, mode masking and spare indexes
    task automatic test_solid_hold_modes();
        write_reg(CFG_LED_MODE, 16'hFFFC);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        write_reg(CFG_DIP_TIME, 16'd1);
        send_request(OP_TICK, 8'h00);
        send_request(OP_DIP, 8'h00);
        send_ticks(3);
        wait_idle();
        write_reg(CFG_LED_MODE, t_cfg'(MODE_HOLD));
        send_request(OP_DIP, 8'hFF);
        send_ticks(3);
        wait_idle();
    endtask

    // Blink with zero and full-scale periods, zero dip time
    task automatic test_blink_periods();
        write_reg(CFG_FAST_PERIOD, 16'd0);
        write_reg(CFG_LED_MODE, t_cfg'(MODE_FAST));
        send_ticks(3);
        wait_idle();
        write_reg(CFG_SLOW_PERIOD, 16'hFFFF);
        write_reg(CFG_LED_MODE, t_cfg'(MODE_SLOW));
        send_ticks(2);
        wait_idle();
        // Shortening the period does not restart the interval
        write_reg(CFG_SLOW_PERIOD, 16'd0);
        write_reg(CFG_DIP_TIME, 16'd0);
        send_request(OP_TICK, 8'h00);
        send_request(OP_DIP, 8'h00);
        send_ticks(2);
        wait_idle();
        write_reg(CFG_FAST_PERIOD, 16'hFFFF);
        write_reg(CFG_LED_MODE, t_cfg'(MODE_FAST));
        send_ticks(2);
        wait_idle();
    endtask

    // Flash against flash, dip and mode writes
    task automatic test_flash_interplay();
        write_reg(CFG_LED_MODE, t_cfg'(MODE_SOLID));
        write_reg(CFG_FLASH_ON_TIME, 16'd1);
        write_reg(CFG_FLASH_OFF_TIME, 16'd0);
        send_request(OP_FLASH, 8'd2);
        send_ticks(2);
        send_request(OP_FLASH, 8'd1);
        send_request(OP_DIP, 8'h00);
        send_ticks(3);
        wait_idle();
        // Dip keeps counting under a flash, then restarts on a second dip
        write_reg(CFG_DIP_TIME, 16'hFFFF);
        send_request(OP_DIP, 8'h00);
        send_request(OP_FLASH, 8'd1);
        send_ticks(3);
        wait_idle();
        write_reg(CFG_DIP_TIME, 16'd2);
        send_request(OP_DIP, 8'h00);
        send_ticks(3);
        wait_idle();
        // Full-scale flash times, cancelled by a mode write
        write_reg(CFG_FLASH_ON_TIME, 16'hFFFF);
        write_reg(CFG_FLASH_OFF_TIME, 16'hFFFF);
        send_request(OP_FLASH, 8'd255);
        send_ticks(2);
        wait_idle();
        write_reg(CFG_LED_MODE, t_cfg'(MODE_SOLID));
        send_ticks(1);
        wait_idle();
    endtask

    // A count of zero runs 256 pulses
    task automatic test_flash_count_wrap();
        write_reg(CFG_FLASH_ON_TIME, 16'd0);
        write_reg(CFG_FLASH_OFF_TIME, 16'd0);
        send_request(OP_FLASH, 8'd0);
        send_ticks(515);
        wait_idle();
    endtask

    // Pick a time: mostly short, now and then full scale
    function automatic t_cfg pick_time(input int unsigned hi);
        if ($urandom_range(7) == 0) return 16'hFFFF;
        return t_cfg'($urandom_range(hi));
    endfunction

    task automatic test_random_traffic();
        int unsigned r;
        t_cnt        cnt;
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            // Receiver idles first, then the sender, then neither
            if (ph < RAND_PHASES / 3) begin
                src_idle_pct  = 20;
                sink_idle_pct = 46;
            end else if (ph < 2 * RAND_PHASES / 3) begin
                src_idle_pct  = 46;
                sink_idle_pct = 20;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_reg(CFG_SLOW_PERIOD, pick_time(12));
            write_reg(CFG_FAST_PERIOD, pick_time(6));
            write_reg(CFG_FLASH_ON_TIME, pick_time(4));
            write_reg(CFG_FLASH_OFF_TIME, pick_time(4));
            write_reg(CFG_DIP_TIME, pick_time(15));
            write_reg(CFG_LED_MODE, t_cfg'($urandom_range(16'hFFFF)));
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                r   = $urandom_range(99);
                cnt = t_cnt'($urandom_range(255));
                if (r < 78) begin
                    send_request(OP_TICK, cnt);
                end else if (r < 87) begin
                    // Mostly short flashes, sometimes any count
                    if ($urandom_range(15) != 0) cnt = t_cnt'($urandom_range(1, 4));
                    send_request(OP_FLASH, cnt);
                end else if (r < 96) begin
                    send_request(OP_DIP, cnt);
                end else begin
                    send_request(OP_SPARE, cnt);
                end
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_TICK;
        req_if.pulse_count = '0;
        reset_led_model();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_solid_hold_modes();
        test_blink_periods();
        test_flash_interplay();
        test_flash_count_wrap();
        test_random_traffic();

        wait_idle();
        repeat (5) @(negedge i_clk);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("status_led_pattern_controller verification clean");
        end else begin
            $display("status_led_pattern_controller verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/slpc_pkg.sv
sv/slpc_req_if.sv
sv/slpc_rsp_if.sv
sv/status_led_pattern_controller.sv
tb/status_led_pattern_controller_tb.sv
